FILE: src/cts_pkg.sv
// Package: token scanner types, constants, keyword and punctuator tables.
package cts_pkg;

  localparam int MaxTokenLen = 255;
  localparam int LineBits = 20;
  localparam int ColumnBits = 12;

  localparam logic [6:0] K_IDENTIFIER = 7'd36;
  localparam logic [6:0] K_NUMBER = 7'd37;
  localparam logic [6:0] K_EOL = 7'd38;
  localparam logic [6:0] K_DOT = 7'd59;
  localparam logic [6:0] K_DOTS = 7'd60;
  localparam logic [6:0] K_SHL = 7'd67;
  localparam logic [6:0] K_SHL_ASSIGN = 7'd68;
  localparam logic [6:0] K_SHR = 7'd74;
  localparam logic [6:0] K_SHR_ASSIGN = 7'd75;
  localparam logic [6:0] K_ERROR = 7'd127;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_IDENT, MODE_NUM, MODE_NUM_EXP, MODE_PUNCT1, MODE_PUNCT2,
    MODE_COMMENT, MODE_STAR, MODE_COMMENT_CR, MODE_CR, MODE_HOLD
  } mode_t;

  typedef struct packed {
    logic [6:0]  kind;
    logic [19:0] line;
    logic [11:0] column;
    logic [7:0]  length;
  } token_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  data;
    logic        eoi;
  } item_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || b == "_";
  endfunction

  function automatic logic is_eol(input logic [7:0] b);
    return b == 8'h0a || b == 8'h0d || b == 8'h0b || b == 8'h0c;
  endfunction

  function automatic logic [6:0] single_kind(input logic [7:0] b);
    logic [6:0] k;
    case (b)
      "!": k = 7'd39;  "#": k = 7'd41;  "%": k = 7'd43;  "&": k = 7'd45;
      "(": k = 7'd48;  ")": k = 7'd49;  "*": k = 7'd50;  "+": k = 7'd52;
      ",": k = 7'd55;  "-": k = 7'd56;  ".": k = 7'd59;  "/": k = 7'd61;
      ":": k = 7'd63;  ";": k = 7'd65;  "<": k = 7'd66;  "=": k = 7'd70;
      ">": k = 7'd73;  "?": k = 7'd77;  "[": k = 7'd79;  "]": k = 7'd80;
      "^": k = 7'd81;  "{": k = 7'd83;  "|": k = 7'd84;  "}": k = 7'd87;
      "~": k = 7'd88;
      default: k = 7'd0;
    endcase
    return k;
  endfunction

  function automatic logic is_singleton(input logic [7:0] b);
    return b == "(" || b == ")" || b == "," || b == ";" || b == "[" ||
           b == "]" || b == "{" || b == "}" || b == "~";
  endfunction

  function automatic logic [6:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
    logic [6:0] k;
    case ({a, b})
      {"!", "="}: k = 7'd40;  {"#", "#"}: k = 7'd42;  {"%", "="}: k = 7'd44;
      {"&", "&"}: k = 7'd46;  {"&", "="}: k = 7'd47;  {"*", "="}: k = 7'd51;
      {"+", "="}: k = 7'd53;  {"+", "+"}: k = 7'd54;  {"-", "="}: k = 7'd57;
      {"-", "-"}: k = 7'd58;  {"/", "="}: k = 7'd62;  {":", ":"}: k = 7'd64;
      {"<", "="}: k = 7'd69;  {"=", "="}: k = 7'd71;  {"=", ">"}: k = 7'd72;
      {">", "="}: k = 7'd76;  {"?", "?"}: k = 7'd78;  {"^", "="}: k = 7'd82;
      {"|", "|"}: k = 7'd85;  {"|", "="}: k = 7'd86;
      default: k = 7'd0;
    endcase
    return k;
  endfunction

  // Full-word keyword match on the first eight bytes, little-endian packed.
  function automatic logic [6:0] keyword_kind(input logic [63:0] p);
    logic [6:0] k;
    case (p)
      64'h6f747561:         k = 7'd1;
      64'h6b61657262:       k = 7'd2;
      64'h65736163:         k = 7'd3;
      64'h72616863:         k = 7'd4;
      64'h74736e6f63:       k = 7'd5;
      64'h65756e69746e6f63: k = 7'd6;
      64'h746c7561666564:   k = 7'd7;
      64'h656c62756f64:     k = 7'd8;
      64'h6f64:             k = 7'd9;
      64'h65736c65:         k = 7'd10;
      64'h6d756e65:         k = 7'd11;
      64'h6e7265747865:     k = 7'd12;
      64'h74616f6c66:       k = 7'd13;
      64'h726f66:           k = 7'd14;
      64'h6f746f67:         k = 7'd15;
      64'h6669:             k = 7'd16;
      64'h746e69:           k = 7'd17;
      64'h656e696c6e69:     k = 7'd18;
      64'h6564756c636e69:   k = 7'd19;
      64'h676e6f6c:         k = 7'd20;
      64'h72657473696765:   k = 7'd36;
      64'h7265747369676572: k = 7'd21;
      64'h6e72757465:       k = 7'd36;
      64'h6e72757465_72:    k = 7'd22;
      64'h74726f6873:       k = 7'd23;
      64'h686374697773:     k = 7'd24;
      64'h64656e676973:     k = 7'd25;
      64'h666f657a6973:     k = 7'd26;
      64'h636974617473:     k = 7'd27;
      64'h746375727473:     k = 7'd28;
      64'h66656470797974:   k = 7'd36;
      64'h666564657079_74:  k = 7'd29;
      64'h6e6f696e75:       k = 7'd30;
      64'h64656e6769736e75: k = 7'd31;
      64'h657375:           k = 7'd32;
      64'h64696f76:         k = 7'd33;
      64'h656c6974616c6f76: k = 7'd34;
      64'h656c696877:       k = 7'd35;
      default:              k = K_IDENTIFIER;
    endcase
    return k;
  endfunction

endpackage

FILE: src/cts_if.sv
// Interfaces: byte input channel and token result channel.
interface cts_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;
  logic       end_of_input;
  modport source (output valid, byte_req, end_of_input, input ready);
  modport sink (input valid, byte_req, end_of_input, output ready);
endinterface

interface cts_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [6:0]  token_kind;
  logic [19:0] line;
  logic [11:0] column;
  logic [7:0]  length;
  logic        last_of_run;
  modport source (output valid, token_kind, line, column, length, last_of_run,
                  input ready);
  modport sink (input valid, token_kind, line, column, length, last_of_run,
                output ready);
endinterface

FILE: src/cts_scan.sv
// Scanner datapath: state registers and per-byte next-state and token logic.
module cts_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  cts_pkg::item_t    item,
  output logic [1:0]        tok_cnt,
  output cts_pkg::token_t   tok0,
  output cts_pkg::token_t   tok1
);

  cts_pkg::mode_t mode_r, mode_nxt;
  logic [63:0] prefix_r, prefix_nxt;
  logic [8:0]  pend_r, pend_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [11:0] scol_r, scol_nxt;
  logic [19:0] sline_r, sline_nxt;
  logic [19:0] cline_r, cline_nxt;
  logic [11:0] ccol_r, ccol_nxt;

  localparam logic [19:0] LineMax = {cts_pkg::LineBits{1'b1}};
  localparam logic [11:0] ColMax = {cts_pkg::ColumnBits{1'b1}};
  localparam logic [7:0] LenMax = 8'(cts_pkg::MaxTokenLen);

  logic [7:0] b, p, len_grow;
  logic [11:0] scol_p1;
  logic [6:0] pk, cls;
  logic paired;

  assign b = item.data;
  assign p = pend_r[7:0];
  assign len_grow = (len_r < LenMax) ? len_r + 8'd1 : len_r;
  assign scol_p1 = (scol_r < ColMax) ? scol_r + 12'd1 : ColMax;
  assign pk = cts_pkg::pair_kind(p, b);
  assign cls = (len_r > 8'd8) ? cts_pkg::K_IDENTIFIER : cts_pkg::keyword_kind(prefix_r);

  // Decide next state and the tokens caused by this byte
  always_comb begin
    logic [6:0] k;
    logic do_idle, hold;
    mode_nxt = mode_r; prefix_nxt = prefix_r; pend_nxt = pend_r;
    len_nxt = len_r; scol_nxt = scol_r; sline_nxt = sline_r;
    cline_nxt = cline_r; ccol_nxt = ccol_r;
    tok_cnt = 2'd0; paired = 1'b0; do_idle = 1'b0; hold = 1'b0;
    tok0 = '{kind: 7'd0, line: sline_r, column: scol_r, length: len_r};
    tok1 = tok0;
    k = 7'd0;
    if (item.eoi) begin
      case (mode_r)
        cts_pkg::MODE_IDENT: begin tok0.kind = cls; tok_cnt = 2'd1; end
        cts_pkg::MODE_NUM, cts_pkg::MODE_NUM_EXP: begin
          tok0.kind = cts_pkg::K_NUMBER; tok_cnt = 2'd1;
        end
        cts_pkg::MODE_PUNCT1: begin tok0.kind = cts_pkg::single_kind(p); tok_cnt = 2'd1; end
        cts_pkg::MODE_PUNCT2: begin
          if (p == ".") begin
            tok0 = '{cts_pkg::K_DOT, sline_r, scol_r, 8'd1};
            tok1 = '{cts_pkg::K_DOT, sline_r, scol_p1, 8'd1};
            tok_cnt = 2'd2;
          end else begin
            tok0.kind = (p == "<") ? cts_pkg::K_SHL : cts_pkg::K_SHR; tok_cnt = 2'd1;
          end
        end
        cts_pkg::MODE_COMMENT, cts_pkg::MODE_STAR, cts_pkg::MODE_COMMENT_CR: begin
          tok0.kind = cts_pkg::K_ERROR; tok_cnt = 2'd1;
        end
        cts_pkg::MODE_HOLD: begin tok0.kind = pend_r[6:0]; tok_cnt = 2'd1; end
        default: ;
      endcase
      mode_nxt = cts_pkg::MODE_IDLE; prefix_nxt = '0; pend_nxt = '0; len_nxt = '0;
      scol_nxt = '0; sline_nxt = '0; cline_nxt = '0; ccol_nxt = '0;
    end else begin
      case (mode_r)
        cts_pkg::MODE_IDENT: begin
          if (cts_pkg::is_word(b)) begin
            if (len_r < 8'd8) prefix_nxt[{len_r[2:0], 3'b000} +: 8] = b;
            len_nxt = len_grow;
          end else begin
            tok0.kind = cls; tok_cnt = 2'd1; do_idle = 1'b1;
          end
        end
        cts_pkg::MODE_NUM, cts_pkg::MODE_NUM_EXP: begin
          if (cts_pkg::is_word(b) || b == "." ||
              (mode_r == cts_pkg::MODE_NUM_EXP && (b == "+" || b == "-"))) begin
            len_nxt = len_grow;
            mode_nxt = (b == "e" || b == "E" || b == "p" || b == "P") ?
                       cts_pkg::MODE_NUM_EXP : cts_pkg::MODE_NUM;
          end else begin
            tok0.kind = cts_pkg::K_NUMBER; tok_cnt = 2'd1; do_idle = 1'b1;
          end
        end
        cts_pkg::MODE_PUNCT1: begin
          if (p == "." && b == ".") begin
            mode_nxt = cts_pkg::MODE_PUNCT2; len_nxt = len_grow;
          end else if (p == "." && cts_pkg::is_digit(b)) begin
            mode_nxt = cts_pkg::MODE_NUM; len_nxt = len_grow;
          end else if (p == "/" && b == "*") begin
            mode_nxt = cts_pkg::MODE_COMMENT; len_nxt = len_grow;
          end else if ((p == "<" || p == ">") && b == p) begin
            mode_nxt = cts_pkg::MODE_PUNCT2; len_nxt = len_grow;
          end else if (pk != 7'd0) begin
            tok0.kind = pk; tok0.length = 8'd2; tok_cnt = 2'd1;
            mode_nxt = cts_pkg::MODE_IDLE;
          end else begin
            tok0.kind = cts_pkg::single_kind(p); tok_cnt = 2'd1; do_idle = 1'b1;
          end
        end
        cts_pkg::MODE_PUNCT2: begin
          if (p == ".") begin
            if (b == ".") begin
              tok0 = '{cts_pkg::K_DOTS, sline_r, scol_r, 8'd3}; tok_cnt = 2'd1;
              mode_nxt = cts_pkg::MODE_IDLE;
            end else if (cts_pkg::is_digit(b)) begin
              tok0 = '{cts_pkg::K_DOT, sline_r, scol_r, 8'd1}; tok_cnt = 2'd1;
              scol_nxt = scol_p1; len_nxt = 8'd2; mode_nxt = cts_pkg::MODE_NUM;
            end else begin
              tok0 = '{cts_pkg::K_DOT, sline_r, scol_r, 8'd1};
              tok1 = '{cts_pkg::K_DOT, sline_r, scol_p1, 8'd1};
              tok_cnt = 2'd2; do_idle = 1'b1; hold = 1'b1;
            end
          end else if (b == "=") begin
            tok0.kind = (p == "<") ? cts_pkg::K_SHL_ASSIGN : cts_pkg::K_SHR_ASSIGN;
            tok0.length = 8'd3; tok_cnt = 2'd1; mode_nxt = cts_pkg::MODE_IDLE;
          end else begin
            tok0.kind = (p == "<") ? cts_pkg::K_SHL : cts_pkg::K_SHR;
            tok_cnt = 2'd1; do_idle = 1'b1;
          end
        end
        cts_pkg::MODE_COMMENT, cts_pkg::MODE_STAR, cts_pkg::MODE_COMMENT_CR: begin
          if (mode_r == cts_pkg::MODE_COMMENT_CR && b == 8'h0a) begin
            len_nxt = len_grow; paired = 1'b1; mode_nxt = cts_pkg::MODE_COMMENT;
          end else begin
            len_nxt = len_grow;
            if (mode_r == cts_pkg::MODE_STAR && b == "/") mode_nxt = cts_pkg::MODE_IDLE;
            else if (b == "*") mode_nxt = cts_pkg::MODE_STAR;
            else begin
              mode_nxt = cts_pkg::MODE_COMMENT;
              if (cts_pkg::is_eol(b)) begin
                tok0 = '{cts_pkg::K_EOL, cline_r, ccol_r, 8'd1}; tok_cnt = 2'd1;
                if (b == 8'h0d) mode_nxt = cts_pkg::MODE_COMMENT_CR;
              end
            end
          end
        end
        cts_pkg::MODE_HOLD: begin
          tok0.kind = pend_r[6:0]; tok_cnt = 2'd1;
          if (pend_r[8] && b == 8'h0a) begin
            paired = 1'b1; mode_nxt = cts_pkg::MODE_IDLE;
          end else do_idle = 1'b1;
        end
        cts_pkg::MODE_CR: begin
          if (b == 8'h0a) begin
            paired = 1'b1; mode_nxt = cts_pkg::MODE_IDLE;
          end else do_idle = 1'b1;
        end
        default: do_idle = 1'b1;
      endcase
      // Start a token or give a one-byte token from the idle state
      if (do_idle) begin
        mode_nxt = cts_pkg::MODE_IDLE;
        k = cts_pkg::is_eol(b) ? cts_pkg::K_EOL : cts_pkg::single_kind(b);
        if (cts_pkg::is_alpha(b) || b == "_") begin
          mode_nxt = cts_pkg::MODE_IDENT; prefix_nxt = {56'd0, b};
          sline_nxt = cline_r; scol_nxt = ccol_r; len_nxt = 8'd1;
        end else if (cts_pkg::is_digit(b)) begin
          mode_nxt = cts_pkg::MODE_NUM;
          sline_nxt = cline_r; scol_nxt = ccol_r; len_nxt = 8'd1;
        end else if (k != 7'd0) begin
          if (!cts_pkg::is_eol(b) && !cts_pkg::is_singleton(b)) begin
            mode_nxt = cts_pkg::MODE_PUNCT1; pend_nxt = {1'b0, b};
            sline_nxt = cline_r; scol_nxt = ccol_r; len_nxt = 8'd1;
          end else if (hold) begin
            mode_nxt = cts_pkg::MODE_HOLD;
            sline_nxt = cline_r; scol_nxt = ccol_r; len_nxt = 8'd1;
            pend_nxt = {b == 8'h0d, 1'b0, k};
          end else begin
            if (tok_cnt == 2'd0) begin
              tok0 = '{k, cline_r, ccol_r, 8'd1};
            end else begin
              tok1 = '{k, cline_r, ccol_r, 8'd1};
            end
            tok_cnt = tok_cnt + 2'd1;
            if (b == 8'h0d) mode_nxt = cts_pkg::MODE_CR;
          end
        end
      end
      // Advance the position
      if (!paired) begin
        if (cts_pkg::is_eol(b)) begin
          if (cline_r < LineMax) cline_nxt = cline_r + 20'd1;
          ccol_nxt = '0;
        end else begin
          ccol_nxt = (ccol_r < ColMax) ? ccol_r + 12'd1 : ColMax;
        end
      end
    end
    if (!item.byte_valid) tok_cnt = 2'd0;
  end

  // Hold the scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= cts_pkg::MODE_IDLE; prefix_r <= '0; pend_r <= '0; len_r <= '0;
      scol_r <= '0; sline_r <= '0; cline_r <= '0; ccol_r <= '0;
    end else if (step) begin
      mode_r <= mode_nxt; prefix_r <= prefix_nxt; pend_r <= pend_nxt; len_r <= len_nxt;
      scol_r <= scol_nxt; sline_r <= sline_nxt; cline_r <= cline_nxt; ccol_r <= ccol_nxt;
    end
  end

  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n) len_r <= LenMax)
    else $error("token length over limit");
  a_step_valid: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> item.byte_valid) else $error("step without item");
  a_eoi_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.eoi) |=> (mode_r == cts_pkg::MODE_IDLE && cline_r == '0 && ccol_r == '0))
    else $error("end of input did not clear state");

endmodule

FILE: src/cts_out.sv
// Result stage: holds up to two tokens and sends them one per transfer.
module cts_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [1:0]        tok_cnt,
  input  cts_pkg::token_t   tok0,
  input  cts_pkg::token_t   tok1,
  output logic              can_load,
  cts_out_if.source         out_ch
);

  logic [1:0] cnt_r, cnt_nxt;
  cts_pkg::token_t t0_r, t1_r;
  logic fire;

  assign fire = out_ch.valid && out_ch.ready;
  // Take a new group when empty or when the last pending token leaves now
  assign can_load = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ch.ready);

  always_comb begin
    cnt_nxt = cnt_r;
    if (fire) cnt_nxt = cnt_r - 2'd1;
    if (load) cnt_nxt = tok_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= 2'd0;
    else cnt_r <= cnt_nxt;
  end

  // Advance the token queue
  always_ff @(posedge clk) begin
    if (load) begin
      t0_r <= tok0; t1_r <= tok1;
    end else if (fire) begin
      t0_r <= t1_r;
    end
  end

  assign out_ch.valid = cnt_r != 2'd0;
  assign out_ch.token_kind = t0_r.kind;
  assign out_ch.line = t0_r.line;
  assign out_ch.column = t0_r.column;
  assign out_ch.length = t0_r.length;
  assign out_ch.last_of_run = cnt_r == 2'd1;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_load_safe: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (cnt_r == 2'd0 || (cnt_r == 2'd1 && fire))) else $error("overwrite of token");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && fire) |=> cnt_r == 2'd1) else $error("bad drain");

endmodule

FILE: src/c_token_scanner_core.sv
// Top level: C token scanner, one byte per cycle in while results are not stalled, token records out.
// Usage:
//   in_ch carries one source byte (byte_req) or an end_of_input mark per
//   transfer. out_ch carries token records: kind, line, column, length and
//   last_of_run, set on the final token that one input transfer causes.
//   Each input transfer yields zero, one or two tokens; a token is reported
//   on the byte that ends it, so it usually appears one byte late.
//   end_of_input flushes any pending token and returns line and column to 0.
// Path: an accepted byte goes through the input register and the scan
//   logic into the result register, from which its first token is
//   presented on out_ch and can transfer when out_ch.ready is high.
// Throughput: one byte per cycle while tokens are taken at once; a byte that
//   gives two tokens occupies the result port for two transfers, and the input
//   register waits for the result queue to hold at most its last token.
// Reset: synchronous, active low; scanner state idle, line and column 0,
//   queues empty.
// Stall: when out_ch.ready is low, the result queue holds, the input
//   register fills and in_ch.ready drops; nothing is lost.
module c_token_scanner_core (
  input  logic       clk,
  input  logic       rst_n,
  cts_in_if.sink     in_ch,
  cts_out_if.source  out_ch
);

  cts_pkg::item_t item_r;
  logic [1:0] tok_cnt;
  cts_pkg::token_t tok0, tok1;
  logic can_load, step;

  // Drain the input register whenever the result stage can take its tokens
  assign step = item_r.byte_valid && can_load;
  assign in_ch.ready = !item_r.byte_valid || step;

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) item_r.byte_valid <= 1'b0;
    else if (in_ch.ready) item_r.byte_valid <= in_ch.valid;
    if (in_ch.ready && in_ch.valid) begin
      item_r.data <= in_ch.byte_req; item_r.eoi <= in_ch.end_of_input;
    end
  end

  cts_scan u_scan (
    .clk(clk), .rst_n(rst_n), .step(step), .item(item_r),
    .tok_cnt(tok_cnt), .tok0(tok0), .tok1(tok1)
  );

  cts_out u_out (
    .clk(clk), .rst_n(rst_n), .load(step), .tok_cnt(tok_cnt),
    .tok0(tok0), .tok1(tok1), .can_load(can_load), .out_ch(out_ch)
  );

endmodule
